### hw/rtl/ohd_pkg.sv
// ----------------------------------------------------------------------------
// ohd_pkg: shared types and constants of the ordered hash dictionary engine
// Store sizes, hash constants, operation codes, item and status structs, states
// ----------------------------------------------------------------------------
`default_nettype none

package ohd_pkg;

    localparam int ENTRY_DEPTH = 256;
    localparam int INDEX_DEPTH = 512;
    localparam int EA_W        = $clog2(ENTRY_DEPTH);
    localparam int IA_W        = $clog2(INDEX_DEPTH);
    localparam int CNT_W       = $clog2(ENTRY_DEPTH + 1);
    localparam int CUR_W       = 9;
    localparam int QUEUE_DEPTH = 2;
    localparam int QA_W        = $clog2(QUEUE_DEPTH);

    localparam logic [63:0] C_GOLD     = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] C_MIX1     = 64'hBF58476D1CE4E5B9;
    localparam logic [63:0] C_MIX2     = 64'h94D049BB133111EB;
    localparam logic [63:0] SEED_RESET = 64'h00000000A0761D64;

    localparam logic [1:0] MODE_GET  = 2'd0;
    localparam logic [1:0] MODE_PUT  = 2'd1;
    localparam logic [1:0] MODE_DEL  = 2'd2;
    localparam logic [1:0] MODE_ITER = 2'd3;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic [1:0]       mode;
        logic [63:0]      key;
        logic [63:0]      value;
        logic [CUR_W-1:0] cursor;
        logic [63:0]      hash;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    typedef struct packed {
        logic clearing;
    } back_status_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PRE,
        F_MUL0,
        F_MUL1,
        F_MUL2,
        F_POST,
        F_PUSH
    } front_state_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LK_RD,
        B_LK_CHK,
        B_LK_ENT,
        B_IT_RD,
        B_IT_CHK,
        B_CP_RD,
        B_CP_WR,
        B_IX_CLR,
        B_RB_RD,
        B_RB_HASH,
        B_FS_RD,
        B_FS_CHK,
        B_INS,
        B_DONE
    } back_state_t;

    typedef enum logic [1:0] {
        AFT_BOOT,
        AFT_DEL,
        AFT_PUT
    } after_t;

endpackage

`default_nettype wire

### hw/rtl/ohd_front.sv
// ----------------------------------------------------------------------------
// ohd_front: input stage and key hash unit
// Takes one item, hashes key xor seed with a shared 32x32 multiplier, queues it
// ----------------------------------------------------------------------------
`default_nettype none

module ohd_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [1:0]                mode,
    input  wire logic [63:0]               key,
    input  wire logic [63:0]               value_in,
    input  wire logic [ohd_pkg::CUR_W-1:0] cursor,
    input  wire logic                      hash_seed_we,
    input  wire logic [63:0]               hash_seed_wdata,
    input  wire logic                      hold,
    input  wire ohd_pkg::q_status_t        q_st,
    output logic                           q_push,
    output ohd_pkg::item_t                 q_item
);

    ohd_pkg::front_state_t state_reg, state_next;
    logic                  round_reg, round_next;
    ohd_pkg::item_t        item_reg, item_next;
    logic [63:0]           y_reg, y_next;
    logic [63:0]           acc_reg, acc_next;
    logic [63:0]           seed_reg;

    logic [63:0] x_pre;
    logic [63:0] c_mul;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;
    logic        accept;

    assign full   = (state_reg != ohd_pkg::F_IDLE) || hold;
    assign accept = push && !full;
    assign q_item = item_reg;

    assign x_pre = (item_reg.key ^ seed_reg) + ohd_pkg::C_GOLD;
    assign c_mul = round_reg ? ohd_pkg::C_MIX2 : ohd_pkg::C_MIX1;
    assign mul_a = (state_reg == ohd_pkg::F_MUL1) ? y_reg[63:32] : y_reg[31:0];
    assign mul_b = (state_reg == ohd_pkg::F_MUL2) ? c_mul[63:32] : c_mul[31:0];
    assign prod  = 64'(mul_a) * 64'(mul_b);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ohd_pkg::F_IDLE;
            round_reg <= 1'b0;
            seed_reg  <= ohd_pkg::SEED_RESET;
        end
        else
        begin
            state_reg <= state_next;
            round_reg <= round_next;
            if (hash_seed_we)
            begin
                seed_reg <= hash_seed_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        y_reg    <= y_next;
        acc_reg  <= acc_next;
    end

    always_comb
    begin
        state_next = state_reg;
        round_next = round_reg;
        item_next  = item_reg;
        y_next     = y_reg;
        acc_next   = acc_reg;
        q_push     = 1'b0;
        unique case (state_reg)
            ohd_pkg::F_IDLE:
            begin
                if (accept)
                begin
                    item_next.mode   = mode;
                    item_next.key    = key;
                    item_next.value  = value_in;
                    item_next.cursor = cursor;
                    round_next       = 1'b0;
                    state_next       = ohd_pkg::F_PRE;
                end
            end
            ohd_pkg::F_PRE:
            begin
                y_next     = x_pre ^ (x_pre >> 30);
                state_next = ohd_pkg::F_MUL0;
            end
            ohd_pkg::F_MUL0:
            begin
                acc_next   = prod;
                state_next = ohd_pkg::F_MUL1;
            end
            ohd_pkg::F_MUL1:
            begin
                acc_next   = acc_reg + {prod[31:0], 32'd0};
                state_next = ohd_pkg::F_MUL2;
            end
            ohd_pkg::F_MUL2:
            begin
                acc_next   = acc_reg + {prod[31:0], 32'd0};
                state_next = ohd_pkg::F_POST;
            end
            ohd_pkg::F_POST:
            begin
                if (!round_reg)
                begin
                    y_next     = acc_reg ^ (acc_reg >> 27);
                    round_next = 1'b1;
                    state_next = ohd_pkg::F_MUL0;
                end
                else
                begin
                    item_next.hash = acc_reg ^ (acc_reg >> 31);
                    state_next     = ohd_pkg::F_PUSH;
                end
            end
            ohd_pkg::F_PUSH:
            begin
                if (!q_st.full)
                begin
                    q_push     = 1'b1;
                    state_next = ohd_pkg::F_IDLE;
                end
            end
            default:
            begin
                state_next = ohd_pkg::F_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/ohd_queue.sv
// ----------------------------------------------------------------------------
// ohd_queue: short item queue between front and back
// Two-entry first-in first-out buffer of hashed items
// ----------------------------------------------------------------------------
`default_nettype none

module ohd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire ohd_pkg::item_t     item_in,
    input  wire logic               pop,
    output ohd_pkg::item_t          item_out,
    output ohd_pkg::q_status_t      q_st
);

    ohd_pkg::item_t                q_mem [ohd_pkg::QUEUE_DEPTH];
    logic [ohd_pkg::QA_W-1:0]      wr_ptr_reg;
    logic [ohd_pkg::QA_W-1:0]      rd_ptr_reg;
    logic [ohd_pkg::QA_W:0]        cnt_reg;
    logic                          do_push;
    logic                          do_pop;

    assign q_st.full  = (cnt_reg == (ohd_pkg::QA_W + 1)'(ohd_pkg::QUEUE_DEPTH));
    assign q_st.empty = (cnt_reg == '0);
    assign do_push    = push && !q_st.full;
    assign do_pop     = pop && !q_st.empty;
    assign item_out   = q_mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_mem[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ohd_back.sv
// ----------------------------------------------------------------------------
// ohd_back: dictionary execution unit
// Entry store, probe index, lookup, insert, delete, iterate, compaction, result
// ----------------------------------------------------------------------------
`default_nettype none

module ohd_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire ohd_pkg::q_status_t         q_st,
    input  wire ohd_pkg::item_t             q_item,
    output logic                            q_pop,
    input  wire logic                       pop,
    output logic                            empty,
    output logic                            found,
    output logic [63:0]                     value_out,
    output logic [63:0]                     key_out,
    output logic [ohd_pkg::CUR_W-1:0]       next_cursor,
    output logic [ohd_pkg::CNT_W-1:0]       entry_count,
    output logic                            status,
    output ohd_pkg::back_status_t           b_st
);

    localparam int EA_W  = ohd_pkg::EA_W;
    localparam int IA_W  = ohd_pkg::IA_W;
    localparam int CNT_W = ohd_pkg::CNT_W;
    localparam int CUR_W = ohd_pkg::CUR_W;

    // memories
    logic [63:0]      hash_mem [ohd_pkg::ENTRY_DEPTH];
    logic [63:0]      key_mem  [ohd_pkg::ENTRY_DEPTH];
    logic [63:0]      val_mem  [ohd_pkg::ENTRY_DEPTH];
    logic             dead_mem [ohd_pkg::ENTRY_DEPTH];
    logic [CNT_W-1:0] idx_mem  [ohd_pkg::INDEX_DEPTH];

    logic [EA_W-1:0]  ent_ra, ent_wa;
    logic             we_hash, we_key, we_val, we_dead;
    logic [63:0]      wd_hash, wd_key, wd_val;
    logic             wd_dead;
    logic [63:0]      hash_q, key_q, val_q;
    logic             dead_q;
    logic [IA_W-1:0]  idx_ra, idx_wa;
    logic             idx_we;
    logic [CNT_W-1:0] idx_wd;
    logic [CNT_W-1:0] idx_q;

    ohd_pkg::back_state_t state_reg, state_next;
    ohd_pkg::after_t      after_reg, after_next;
    ohd_pkg::item_t       item_reg, item_next;
    logic [IA_W-1:0]      slot_reg, slot_next;
    logic [IA_W-1:0]      n_reg, n_next;
    logic [IA_W-1:0]      clr_reg, clr_next;
    logic [EA_W-1:0]      pos_reg, pos_next;
    logic [CNT_W-1:0]     used_reg, used_next;
    logic [CNT_W-1:0]     live_reg, live_next;
    logic [CNT_W-1:0]     tomb_reg, tomb_next;
    logic [CNT_W-1:0]     rd_reg, rd_next;
    logic [CNT_W-1:0]     wr_reg, wr_next;
    logic [CUR_W-1:0]     cur_reg, cur_next;

    logic                 res_found_reg, res_found_next;
    logic [63:0]          res_val_reg, res_val_next;
    logic [63:0]          res_key_reg, res_key_next;
    logic [CUR_W-1:0]     res_ncur_reg, res_ncur_next;
    logic                 res_status_reg, res_status_next;

    logic                 out_valid_reg, out_valid_next;
    logic                 out_found_reg;
    logic [63:0]          out_val_reg;
    logic [63:0]          out_key_reg;
    logic [CUR_W-1:0]     out_ncur_reg;
    logic [CNT_W-1:0]     out_count_reg;
    logic                 out_status_reg;
    logic                 out_load;

    logic                 lk_miss, lk_free, lk_adv;
    logic                 store_full;
    logic                 last_probe;
    logic                 rebuilding;
    logic [CNT_W-1:0]     live_dec;
    logic [CNT_W-1:0]     tomb_inc;

    assign empty       = !out_valid_reg;
    assign found       = out_found_reg;
    assign value_out   = out_val_reg;
    assign key_out     = out_key_reg;
    assign next_cursor = out_ncur_reg;
    assign entry_count = out_count_reg;
    assign status      = out_status_reg;
    assign b_st.clearing = (after_reg == ohd_pkg::AFT_BOOT);

    assign store_full = (used_reg >= CNT_W'(ohd_pkg::ENTRY_DEPTH));
    assign last_probe = (n_reg == IA_W'(ohd_pkg::INDEX_DEPTH - 1));
    assign rebuilding = (rd_reg < used_reg);
    assign live_dec   = (live_reg != '0) ? live_reg - 1'b1 : live_reg;
    assign tomb_inc   = tomb_reg + 1'b1;

    always_ff @(posedge clk)
    begin
        if (we_hash)
        begin
            hash_mem[ent_wa] <= wd_hash;
        end
        if (we_key)
        begin
            key_mem[ent_wa] <= wd_key;
        end
        if (we_val)
        begin
            val_mem[ent_wa] <= wd_val;
        end
        if (we_dead)
        begin
            dead_mem[ent_wa] <= wd_dead;
        end
        hash_q <= hash_mem[ent_ra];
        key_q  <= key_mem[ent_ra];
        val_q  <= val_mem[ent_ra];
        dead_q <= dead_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (idx_we)
        begin
            idx_mem[idx_wa] <= idx_wd;
        end
        idx_q <= idx_mem[idx_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ohd_pkg::B_IX_CLR;
            after_reg     <= ohd_pkg::AFT_BOOT;
            clr_reg       <= '0;
            used_reg      <= '0;
            live_reg      <= '0;
            tomb_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            after_reg     <= after_next;
            clr_reg       <= clr_next;
            used_reg      <= used_next;
            live_reg      <= live_next;
            tomb_reg      <= tomb_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        slot_reg       <= slot_next;
        n_reg          <= n_next;
        pos_reg        <= pos_next;
        rd_reg         <= rd_next;
        wr_reg         <= wr_next;
        cur_reg        <= cur_next;
        res_found_reg  <= res_found_next;
        res_val_reg    <= res_val_next;
        res_key_reg    <= res_key_next;
        res_ncur_reg   <= res_ncur_next;
        res_status_reg <= res_status_next;
        if (out_load)
        begin
            out_found_reg  <= res_found_reg;
            out_val_reg    <= res_val_reg;
            out_key_reg    <= res_key_reg;
            out_ncur_reg   <= res_ncur_reg;
            out_count_reg  <= live_reg;
            out_status_reg <= res_status_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        after_next      = after_reg;
        item_next       = item_reg;
        slot_next       = slot_reg;
        n_next          = n_reg;
        clr_next        = clr_reg;
        pos_next        = pos_reg;
        used_next       = used_reg;
        live_next       = live_reg;
        tomb_next       = tomb_reg;
        rd_next         = rd_reg;
        wr_next         = wr_reg;
        cur_next        = cur_reg;
        res_found_next  = res_found_reg;
        res_val_next    = res_val_reg;
        res_key_next    = res_key_reg;
        res_ncur_next   = res_ncur_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !pop;
        out_load        = 1'b0;
        q_pop           = 1'b0;
        ent_ra          = '0;
        ent_wa          = pos_reg;
        we_hash         = 1'b0;
        we_key          = 1'b0;
        we_val          = 1'b0;
        we_dead         = 1'b0;
        wd_hash         = item_reg.hash;
        wd_key          = item_reg.key;
        wd_val          = item_reg.value;
        wd_dead         = 1'b0;
        idx_ra          = slot_reg;
        idx_wa          = slot_reg;
        idx_we          = 1'b0;
        idx_wd          = '0;
        lk_miss         = 1'b0;
        lk_free         = 1'b0;
        lk_adv          = 1'b0;

        unique case (state_reg)
            ohd_pkg::B_IDLE:
            begin
                if (!q_st.empty)
                begin
                    q_pop           = 1'b1;
                    item_next       = q_item;
                    res_found_next  = 1'b0;
                    res_val_next    = '0;
                    res_key_next    = '0;
                    res_ncur_next   = '0;
                    res_status_next = ohd_pkg::STATUS_OK;
                    slot_next       = q_item.hash[IA_W-1:0];
                    n_next          = '0;
                    cur_next        = q_item.cursor;
                    if (q_item.mode == ohd_pkg::MODE_ITER)
                    begin
                        state_next = ohd_pkg::B_IT_RD;
                    end
                    else
                    begin
                        state_next = ohd_pkg::B_LK_RD;
                    end
                end
            end
            ohd_pkg::B_LK_RD:
            begin
                state_next = ohd_pkg::B_LK_CHK;
            end
            ohd_pkg::B_LK_CHK:
            begin
                if (idx_q == '0)
                begin
                    lk_miss = 1'b1;
                    lk_free = 1'b1;
                end
                else if (idx_q <= used_reg)
                begin
                    pos_next   = EA_W'(idx_q - 1'b1);
                    ent_ra     = EA_W'(idx_q - 1'b1);
                    state_next = ohd_pkg::B_LK_ENT;
                end
                else
                begin
                    lk_adv = 1'b1;
                end
            end
            ohd_pkg::B_LK_ENT:
            begin
                if (!dead_q && hash_q == item_reg.hash && key_q == item_reg.key)
                begin
                    case (item_reg.mode)
                        ohd_pkg::MODE_PUT:
                        begin
                            we_val     = 1'b1;
                            state_next = ohd_pkg::B_DONE;
                        end
                        ohd_pkg::MODE_DEL:
                        begin
                            res_found_next = 1'b1;
                            res_val_next   = val_q;
                            we_dead        = 1'b1;
                            wd_dead        = 1'b1;
                            we_val         = 1'b1;
                            wd_val         = '0;
                            live_next      = live_dec;
                            tomb_next      = tomb_inc;
                            if (tomb_inc > live_dec)
                            begin
                                after_next = ohd_pkg::AFT_DEL;
                                rd_next    = '0;
                                wr_next    = '0;
                                state_next = ohd_pkg::B_CP_RD;
                            end
                            else
                            begin
                                state_next = ohd_pkg::B_DONE;
                            end
                        end
                        default:
                        begin
                            res_found_next = 1'b1;
                            res_val_next   = val_q;
                            state_next     = ohd_pkg::B_DONE;
                        end
                    endcase
                end
                else
                begin
                    lk_adv = 1'b1;
                end
            end
            ohd_pkg::B_IT_RD:
            begin
                if (int'(cur_reg) < int'(used_reg))
                begin
                    ent_ra     = EA_W'(cur_reg);
                    state_next = ohd_pkg::B_IT_CHK;
                end
                else
                begin
                    res_ncur_next = cur_reg;
                    state_next    = ohd_pkg::B_DONE;
                end
            end
            ohd_pkg::B_IT_CHK:
            begin
                cur_next = cur_reg + 1'b1;
                if (dead_q)
                begin
                    state_next = ohd_pkg::B_IT_RD;
                end
                else
                begin
                    res_found_next = 1'b1;
                    res_key_next   = key_q;
                    res_val_next   = val_q;
                    res_ncur_next  = cur_reg + 1'b1;
                    state_next     = ohd_pkg::B_DONE;
                end
            end
            ohd_pkg::B_CP_RD:
            begin
                if (rd_reg < used_reg)
                begin
                    ent_ra     = EA_W'(rd_reg);
                    state_next = ohd_pkg::B_CP_WR;
                end
                else
                begin
                    used_next  = wr_reg;
                    tomb_next  = '0;
                    clr_next   = '0;
                    state_next = ohd_pkg::B_IX_CLR;
                end
            end
            ohd_pkg::B_CP_WR:
            begin
                if (!dead_q)
                begin
                    ent_wa  = EA_W'(wr_reg);
                    we_hash = 1'b1;
                    we_key  = 1'b1;
                    we_val  = 1'b1;
                    we_dead = 1'b1;
                    wd_hash = hash_q;
                    wd_key  = key_q;
                    wd_val  = val_q;
                    wd_dead = 1'b0;
                    wr_next = wr_reg + 1'b1;
                end
                rd_next    = rd_reg + 1'b1;
                state_next = ohd_pkg::B_CP_RD;
            end
            ohd_pkg::B_IX_CLR:
            begin
                idx_we = 1'b1;
                idx_wa = clr_reg;
                idx_wd = '0;
                if (clr_reg == IA_W'(ohd_pkg::INDEX_DEPTH - 1))
                begin
                    if (after_reg == ohd_pkg::AFT_BOOT)
                    begin
                        after_next = ohd_pkg::AFT_DEL;
                        state_next = ohd_pkg::B_IDLE;
                    end
                    else
                    begin
                        rd_next    = '0;
                        state_next = ohd_pkg::B_RB_RD;
                    end
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            ohd_pkg::B_RB_RD:
            begin
                if (rd_reg < used_reg)
                begin
                    ent_ra     = EA_W'(rd_reg);
                    state_next = ohd_pkg::B_RB_HASH;
                end
                else if (after_reg == ohd_pkg::AFT_PUT && !store_full)
                begin
                    slot_next  = item_reg.hash[IA_W-1:0];
                    n_next     = '0;
                    state_next = ohd_pkg::B_FS_RD;
                end
                else
                begin
                    if (after_reg == ohd_pkg::AFT_PUT)
                    begin
                        res_status_next = ohd_pkg::STATUS_FULL;
                    end
                    state_next = ohd_pkg::B_DONE;
                end
            end
            ohd_pkg::B_RB_HASH:
            begin
                slot_next  = hash_q[IA_W-1:0];
                n_next     = '0;
                state_next = ohd_pkg::B_FS_RD;
            end
            ohd_pkg::B_FS_RD:
            begin
                state_next = ohd_pkg::B_FS_CHK;
            end
            ohd_pkg::B_FS_CHK:
            begin
                if (idx_q == '0)
                begin
                    if (rebuilding)
                    begin
                        idx_we     = 1'b1;
                        idx_wd     = rd_reg + 1'b1;
                        rd_next    = rd_reg + 1'b1;
                        state_next = ohd_pkg::B_RB_RD;
                    end
                    else
                    begin
                        state_next = ohd_pkg::B_INS;
                    end
                end
                else if (last_probe)
                begin
                    if (rebuilding)
                    begin
                        rd_next    = rd_reg + 1'b1;
                        state_next = ohd_pkg::B_RB_RD;
                    end
                    else
                    begin
                        res_status_next = ohd_pkg::STATUS_FULL;
                        state_next      = ohd_pkg::B_DONE;
                    end
                end
                else
                begin
                    slot_next  = slot_reg + 1'b1;
                    n_next     = n_reg + 1'b1;
                    state_next = ohd_pkg::B_FS_RD;
                end
            end
            ohd_pkg::B_INS:
            begin
                ent_wa     = EA_W'(used_reg);
                we_hash    = 1'b1;
                we_key     = 1'b1;
                we_val     = 1'b1;
                we_dead    = 1'b1;
                wd_dead    = 1'b0;
                idx_we     = 1'b1;
                idx_wd     = used_reg + 1'b1;
                used_next  = used_reg + 1'b1;
                live_next  = live_reg + 1'b1;
                state_next = ohd_pkg::B_DONE;
            end
            ohd_pkg::B_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ohd_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = ohd_pkg::B_IDLE;
            end
        endcase

        if (lk_adv)
        begin
            if (last_probe)
            begin
                lk_miss = 1'b1;
            end
            else
            begin
                slot_next  = slot_reg + 1'b1;
                n_next     = n_reg + 1'b1;
                state_next = ohd_pkg::B_LK_RD;
            end
        end

        if (lk_miss)
        begin
            if (item_reg.mode != ohd_pkg::MODE_PUT)
            begin
                state_next = ohd_pkg::B_DONE;
            end
            else if (store_full && tomb_reg != '0)
            begin
                after_next = ohd_pkg::AFT_PUT;
                rd_next    = '0;
                wr_next    = '0;
                state_next = ohd_pkg::B_CP_RD;
            end
            else if (!store_full && lk_free)
            begin
                state_next = ohd_pkg::B_INS;
            end
            else
            begin
                res_status_next = ohd_pkg::STATUS_FULL;
                state_next      = ohd_pkg::B_DONE;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/ordered_hash_dict_engine_top.sv
// ----------------------------------------------------------------------------
// ordered_hash_dict_engine_top: insertion-ordered hash dictionary engine
// Items (get, put, delete, iterate step) go in through a queue-like input
// port; one result per item comes out through a queue-like result port.
// Input transfer: push high and full low at a rising edge. Result transfer:
// pop high and empty low; the oldest result sits on the result ports while
// empty is low. hash_seed must be written with hash_seed_we only while the
// block idles; the block itself does not enforce this. The front unit hashes
// the key with its shared 32x32 multiplier, and the back unit then probes
// the index, or for iterate skips deleted entries. A compaction copies the
// live stored entries down, clears the index and rebuilds it by probing for
// each live entry. The front unit takes a new item only once it has pushed
// the last one into the queue, while the back unit works on earlier items.
// After reset, full stays high while the index is cleared.
// When the receiver stalls, one result waits in the output register, the
// back unit holds its next result, the two-entry queue fills and then full
// rises.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_hash_dict_engine_top (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [1:0]                mode,
    input  wire logic [63:0]               key,
    input  wire logic [63:0]               value_in,
    input  wire logic [ohd_pkg::CUR_W-1:0] cursor,
    input  wire logic                      hash_seed_we,
    input  wire logic [63:0]               hash_seed_wdata,
    output logic                           empty,
    input  wire logic                      pop,
    output logic                           found,
    output logic [63:0]                    value_out,
    output logic [63:0]                    key_out,
    output logic [ohd_pkg::CUR_W-1:0]      next_cursor,
    output logic [ohd_pkg::CNT_W-1:0]      entry_count,
    output logic                           status
);

    ohd_pkg::q_status_t    q_st;
    ohd_pkg::item_t        q_in_item;
    ohd_pkg::item_t        q_out_item;
    ohd_pkg::back_status_t b_st;
    logic                  q_push;
    logic                  q_pop;

    ohd_front u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .mode            (mode),
        .key             (key),
        .value_in        (value_in),
        .cursor          (cursor),
        .hash_seed_we    (hash_seed_we),
        .hash_seed_wdata (hash_seed_wdata),
        .hold            (b_st.clearing),
        .q_st            (q_st),
        .q_push          (q_push),
        .q_item          (q_in_item)
    );

    ohd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (q_in_item),
        .pop      (q_pop),
        .item_out (q_out_item),
        .q_st     (q_st)
    );

    ohd_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_st        (q_st),
        .q_item      (q_out_item),
        .q_pop       (q_pop),
        .pop         (pop),
        .empty       (empty),
        .found       (found),
        .value_out   (value_out),
        .key_out     (key_out),
        .next_cursor (next_cursor),
        .entry_count (entry_count),
        .status      (status),
        .b_st        (b_st)
    );

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> entry_count <= ohd_pkg::CNT_W'(ohd_pkg::ENTRY_DEPTH))
        else $error("entry count above store capacity");

    a_full_not_found: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status) |-> !found)
        else $error("refused put reports a found entry");

    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        b_st.clearing |-> full)
        else $error("input open during index clear");

    a_pop_dequeues: assert property (@(posedge clk) disable iff (!rst_n)
        (q_pop && !q_push) |=> !q_st.full)
        else $error("queue still full after a transfer out");

endmodule

`default_nettype wire
